FILE: rtl/set_pkg.sv
// Shared types and constants for the Sobel edge threshold block.
// Used by the top, set_grad and set_checker in rtl/; depends on nothing.
`timescale 1ns / 1ps

package set_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd2;

  // Register field widths and reset values
  localparam int unsigned CFG_DATA_W    = 13;
  localparam int unsigned IMG_WIDTH_W   = 12;
  localparam int unsigned IMG_HEIGHT_W  = 13;
  localparam int unsigned THRESH_W      = 10;
  localparam logic [IMG_WIDTH_W-1:0]  IMG_WIDTH_RST  = 12'd512;
  localparam logic [IMG_HEIGHT_W-1:0] IMG_HEIGHT_RST = 13'd512;
  localparam logic [THRESH_W-1:0]     THRESH_RST     = 10'd125;

  localparam int unsigned PIX_W = 8;

  // Gray weights, sum to 256
  localparam logic [PIX_W-1:0] GRAY_WR = 8'd77;
  localparam logic [PIX_W-1:0] GRAY_WG = 8'd151;
  localparam logic [PIX_W-1:0] GRAY_WB = 8'd28;

  localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
  localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pixel_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] gray;
    logic             window_valid;
    logic             edge_x;
    logic             edge_y;
    logic [PIX_W-1:0] edge_pixel;
    logic             frame_end;
  } result_t;

  // 3x3 gray window, row-major, entry 0 is top-left
  typedef logic [8:0][PIX_W-1:0] window_t;

  typedef struct packed {
    logic edge_x;
    logic edge_y;
  } grad_flags_t;

endpackage

FILE: rtl/sobel_edge_threshold_top.sv
// Top level of the streaming 3x3 Sobel edge detector with threshold.
// Depends on set_pkg, set_ram (line stores) and set_grad (gradients).
`timescale 1ns / 1ps
//
//  Channel  Dir  Handshake                Payload
//  -------  ---  -----------------------  ---------------------------------
//  in       in   in_valid_i/in_stall_o    set_pkg::pixel_in_t (r, g, b)
//  out      out  out_valid_o/out_stall_i  set_pkg::result_t
//  cfg      in   cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
//  One pixel per clock sustained while the output does not stall; each
//  pixel's result passes the input stage, where the line store is read, and
//  then the result register. Reset clears config to its defaults, the raster
//  position and the window; the line store holds no valid state and needs no
//  clearing pass. An output stall holds the result register; new pixels keep
//  coming in until the input stage is occupied too.

module sobel_edge_threshold_top #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  set_pkg::pixel_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output set_pkg::result_t                out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [set_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [set_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);   // column index bits
  localparam int unsigned RW = $clog2(MAX_HEIGHT);  // row index bits
  localparam int unsigned PW = set_pkg::PIX_W;
  localparam int unsigned MW = 2 * PW;               // one line store word
  localparam int unsigned GW = 2 * PW;               // gray product sum

  // ---------------------------------------------------------------------
  // Configuration registers: always ready, unknown indexes are dropped
  // ---------------------------------------------------------------------
  logic [set_pkg::IMG_WIDTH_W-1:0]  img_width_q;
  logic [set_pkg::IMG_HEIGHT_W-1:0] img_height_q;
  logic [set_pkg::THRESH_W-1:0]     thresh_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_width_q  <= set_pkg::IMG_WIDTH_RST;
      img_height_q <= set_pkg::IMG_HEIGHT_RST;
      thresh_q     <= set_pkg::THRESH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        set_pkg::CFG_IMAGE_WIDTH:  img_width_q  <= cfg_data_i[set_pkg::IMG_WIDTH_W-1:0];
        set_pkg::CFG_IMAGE_HEIGHT: img_height_q <= cfg_data_i[set_pkg::IMG_HEIGHT_W-1:0];
        set_pkg::CFG_THRESHOLD:    thresh_q     <= cfg_data_i[set_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the frame size to 3..MAX
  logic [CW:0] w_eff;
  logic [RW:0] h_eff;

  always_comb begin
    if (img_width_q < set_pkg::IMG_WIDTH_W'(3)) begin
      w_eff = (CW+1)'(3);
    end else if (32'(img_width_q) > 32'(MAX_WIDTH)) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(img_width_q);
    end
    if (img_height_q < set_pkg::IMG_HEIGHT_W'(3)) begin
      h_eff = (RW+1)'(3);
    end else if (32'(img_height_q) > 32'(MAX_HEIGHT)) begin
      h_eff = (RW+1)'(MAX_HEIGHT);
    end else begin
      h_eff = (RW+1)'(img_height_q);
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline handshake: stage 1 holds the item whose line store word sits
  // on the RAM output; the result register parts it from the consumer.
  // ---------------------------------------------------------------------
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic accept, adv1;

  assign adv1       = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv1;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (adv1) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv1) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 0: raster position, gray conversion, line store read
  // ---------------------------------------------------------------------
  logic [CW-1:0] col_q, col_d, col_cur;
  logic [RW-1:0] row_q, row_d, row_cur;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_wrap, row_inc;
  logic          col_wrap;
  logic [GW-1:0] gray_sum;
  logic [PW-1:0] gray_s0;
  logic          full_s0, fend_s0;

  always_comb begin
    // Wrap first in case the size shrank since the last pixel
    col_wrap = {1'b0, col_q} >= w_eff;
    col_cur  = col_wrap ? '0 : col_q;
    row_wrap = {1'b0, row_q} + (RW+1)'(col_wrap);
    row_cur  = (row_wrap >= h_eff) ? '0 : row_wrap[RW-1:0];

    // Advance to the next pixel
    col_inc = {1'b0, col_cur} + (CW+1)'(1);
    row_inc = {1'b0, row_cur} + (RW+1)'(1);
    if (col_inc >= w_eff) begin
      col_d = '0;
      row_d = (row_inc >= h_eff) ? '0 : row_inc[RW-1:0];
    end else begin
      col_d = col_inc[CW-1:0];
      row_d = row_cur;
    end

    full_s0 = (row_cur >= RW'(2)) && (col_cur >= CW'(2));
    fend_s0 = (row_inc == h_eff) && (col_inc == w_eff);

    gray_sum = GW'(in_data_i.red)   * GW'(set_pkg::GRAY_WR)
             + GW'(in_data_i.green) * GW'(set_pkg::GRAY_WG)
             + GW'(in_data_i.blue)  * GW'(set_pkg::GRAY_WB);
    gray_s0  = gray_sum[GW-1:PW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Stage 1 payload
  logic [PW-1:0] s1_gray_q;
  logic [CW-1:0] s1_col_q;
  logic          s1_full_q, s1_fend_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_gray_q <= gray_s0;
      s1_col_q  <= col_cur;
      s1_full_q <= full_s0;
      s1_fend_q <= fend_s0;
    end
  end

  // ---------------------------------------------------------------------
  // Line stores: one word per column, {row above above, row above}
  // Read at acceptance, write back {row above, this row} when stage 1 moves.
  // ---------------------------------------------------------------------
  logic [MW-1:0] ls_rdata;
  logic [PW-1:0] ls_top, ls_mid;

  set_ram #(
    .WIDTH (MW),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (adv1),
    .waddr_i (s1_col_q),
    .wdata_i ({ls_mid, s1_gray_q}),
    .re_i    (accept),
    .raddr_i (col_cur),
    .rdata_o (ls_rdata)
  );

  assign ls_top = ls_rdata[MW-1:PW];
  assign ls_mid = ls_rdata[PW-1:0];

  // ---------------------------------------------------------------------
  // Stage 1: shift window left, bring in the new column, test gradients
  // ---------------------------------------------------------------------
  set_pkg::window_t     win_q, win_d;
  set_pkg::grad_flags_t flags;
  set_pkg::result_t     res_d, res_q;

  always_comb begin
    win_d    = win_q;
    win_d[0] = win_q[1];
    win_d[1] = win_q[2];
    win_d[2] = ls_top;
    win_d[3] = win_q[4];
    win_d[4] = win_q[5];
    win_d[5] = ls_mid;
    win_d[6] = win_q[7];
    win_d[7] = win_q[8];
    win_d[8] = s1_gray_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (adv1) begin
      win_q <= win_d;
    end
  end

  set_grad u_grad (
    .win_i    (win_d),
    .gray_i   (s1_gray_q),
    .full_i   (s1_full_q),
    .thresh_i (thresh_q),
    .flags_o  (flags)
  );

  always_comb begin
    res_d.gray         = s1_gray_q;
    res_d.window_valid = s1_full_q;
    res_d.edge_x       = flags.edge_x;
    res_d.edge_y       = flags.edge_y;
    res_d.edge_pixel   = (flags.edge_x || flags.edge_y) ? set_pkg::EDGE_ON
                                                        : set_pkg::EDGE_OFF;
    res_d.frame_end    = s1_fend_q;
  end

  // Result register: hold while stalled
  always_ff @(posedge clk_i) begin
    if (adv1) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

endmodule

FILE: rtl/set_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

module set_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/set_grad.sv
// Sobel gradients over a 3x3 gray window and threshold test per axis.
// Depends on set_pkg for the window and flag types.
`timescale 1ns / 1ps

module set_grad (
  input  set_pkg::window_t                 win_i,
  input  logic [set_pkg::PIX_W-1:0]        gray_i,
  input  logic                             full_i,
  input  logic [set_pkg::THRESH_W-1:0]     thresh_i,
  output set_pkg::grad_flags_t             flags_o
);

  localparam int unsigned SUM_W = set_pkg::PIX_W + 2;
  localparam int unsigned GRD_W = SUM_W + 2;

  logic [SUM_W-1:0]        gx_pos, gx_neg, gy_pos, gy_neg;
  logic signed [GRD_W-1:0] gx, gy, thr_s;
  logic                    gray_hit;

  always_comb begin
    gx_pos = SUM_W'(win_i[2]) + SUM_W'({win_i[5], 1'b0}) + SUM_W'(win_i[8]);
    gx_neg = SUM_W'(win_i[0]) + SUM_W'({win_i[3], 1'b0}) + SUM_W'(win_i[6]);
    gy_pos = SUM_W'(win_i[6]) + SUM_W'({win_i[7], 1'b0}) + SUM_W'(win_i[8]);
    gy_neg = SUM_W'(win_i[0]) + SUM_W'({win_i[1], 1'b0}) + SUM_W'(win_i[2]);
    gx     = $signed({2'b00, gx_pos}) - $signed({2'b00, gx_neg});
    gy     = $signed({2'b00, gy_pos}) - $signed({2'b00, gy_neg});
    thr_s  = $signed(GRD_W'(thresh_i));
    // Border pixels fall back to thresholded gray on both axes
    gray_hit = {2'b00, gray_i} > thresh_i;
    if (full_i) begin
      flags_o.edge_x = gx > thr_s;
      flags_o.edge_y = gy > thr_s;
    end else begin
      flags_o.edge_x = gray_hit;
      flags_o.edge_y = gray_hit;
    end
  end

endmodule

FILE: rtl/set_checker.sv
// Port-level checks for sobel_edge_threshold_top, attached by bind.
// Depends on set_pkg for the payload types.
`timescale 1ns / 1ps

module set_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input set_pkg::result_t                out_data_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed under stall");

  // Combined pixel follows edge_x and edge_y
  a_edge_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.edge_pixel ==
                     {8{out_data_o.edge_x | out_data_o.edge_y}}))
    else $error("edge_pixel disagrees with edge bits");

  // Border pixels mark both axes alike
  a_border_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.window_valid |->
      out_data_o.edge_x == out_data_o.edge_y)
    else $error("border pixel with differing edge bits");

  // The last pixel of a frame always closes a full window
  a_fend_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_end |-> out_data_o.window_valid)
    else $error("frame end without full window");

endmodule

bind sobel_edge_threshold_top set_checker u_set_checker (.*);

FILE: tb/sv/edge_scoreboard_pkg.sv
// Scoreboard for the Sobel edge threshold testbench: predicts every result.
// Depends on set_pkg for the payload types, register indexes and constants.
`timescale 1ns / 1ps

package edge_scoreboard_pkg;
  import set_pkg::*;

  localparam int unsigned LINE_DEPTH     = 2048;
  localparam int unsigned FRAME_ROWS_MAX = 4096;
  localparam int unsigned REPORT_MAX     = 40;

  class edge_scoreboard;
    logic [IMG_WIDTH_W-1:0]  width_reg;
    logic [IMG_HEIGHT_W-1:0] height_reg;
    logic [THRESH_W-1:0]     thresh_reg;
    // two previous gray rows, then the 3x3 window (row-major, 0 is top-left)
    logic [PIX_W-1:0]        line_mem [2][LINE_DEPTH];
    logic [PIX_W-1:0]        win [9];
    int unsigned             col_pos;
    int unsigned             row_pos;
    result_t                 awaited_results [$];
    int unsigned             mismatches;
    int unsigned             results_checked;
    int unsigned             windows_seen;
    int unsigned             edges_seen;
    int unsigned             frame_ends_seen;

    function new();
      width_reg  = IMG_WIDTH_RST;
      height_reg = IMG_HEIGHT_RST;
      thresh_reg = THRESH_RST;
      foreach (line_mem[i, j]) line_mem[i][j] = '0;
      foreach (win[k]) win[k] = '0;
      col_pos = 0;
      row_pos = 0;
      mismatches = 0;
      results_checked = 0;
      windows_seen = 0;
      edges_seen = 0;
      frame_ends_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_IMAGE_WIDTH:  width_reg  = data[IMG_WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_reg = data[IMG_HEIGHT_W-1:0];
        CFG_THRESHOLD:    thresh_reg = data[THRESH_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned row_len();
      if (width_reg < 3) return 3;
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return width_reg;
    endfunction

    function int unsigned frame_rows();
      if (height_reg < 3) return 3;
      if (height_reg > FRAME_ROWS_MAX) return FRAME_ROWS_MAX;
      return height_reg;
    endfunction

    // Pixels still needed to close the current frame, after any pending wrap.
    function int unsigned pixels_left_in_frame();
      int unsigned w, h, c, r;
      w = row_len();
      h = frame_rows();
      c = col_pos;
      r = row_pos;
      if (c >= w) begin
        c = 0;
        r++;
      end
      if (r >= h) r = 0;
      return (h - r) * w - c;
    endfunction

    function void note_pixel(pixel_in_t px);
      int unsigned w, h, col, row, luma, up2, up1;
      int gx, gy;
      logic full, ex, ey;
      result_t want;
      w = row_len();
      h = frame_rows();
      luma = (int'(GRAY_WR) * px.red + int'(GRAY_WG) * px.green
              + int'(GRAY_WB) * px.blue) >> 8;
      // a size that shrank under the raster position wraps it
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      col = col_pos;
      row = row_pos;
      up2 = line_mem[0][col];
      up1 = line_mem[1][col];
      line_mem[0][col] = up1[PIX_W-1:0];
      line_mem[1][col] = luma[PIX_W-1:0];
      for (int k = 0; k < 3; k++) begin
        win[3*k]   = win[3*k+1];
        win[3*k+1] = win[3*k+2];
      end
      win[2] = up2[PIX_W-1:0];
      win[5] = up1[PIX_W-1:0];
      win[8] = luma[PIX_W-1:0];
      full = (row >= 2) && (col >= 2);
      if (full) begin
        gx = (int'(win[2]) + 2 * int'(win[5]) + int'(win[8]))
           - (int'(win[0]) + 2 * int'(win[3]) + int'(win[6]));
        gy = (int'(win[6]) + 2 * int'(win[7]) + int'(win[8]))
           - (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]));
        ex = gx > int'(thresh_reg);
        ey = gy > int'(thresh_reg);
        windows_seen++;
      end else begin
        // border pixel: both bits follow the thresholded gray
        ex = luma > thresh_reg;
        ey = ex;
      end
      want.gray         = luma[PIX_W-1:0];
      want.window_valid = full;
      want.edge_x       = ex;
      want.edge_y       = ey;
      want.edge_pixel   = (ex || ey) ? EDGE_ON : EDGE_OFF;
      want.frame_end    = (row + 1 == h) && (col + 1 == w);
      if (full && (ex || ey)) edges_seen++;
      if (want.frame_end) frame_ends_seen++;
      awaited_results.push_back(want);
      col_pos = col + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = row + 1;
        if (row_pos >= h) row_pos = 0;
      end
    endfunction

    function void flag(string field, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
      if (got === want) return;
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      else if (mismatches == REPORT_MAX + 1)
        $display("%0t: further mismatches not shown", $time);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing awaited, expected none, got %h", $time, got);
        return;
      end
      want = awaited_results.pop_front();
      results_checked++;
      flag("gray", want.gray, got.gray);
      flag("window_valid", want.window_valid, got.window_valid);
      flag("edge_x", want.edge_x, got.edge_x);
      flag("edge_y", want.edge_y, got.edge_y);
      flag("edge_pixel", want.edge_pixel, got.edge_pixel);
      flag("frame_end", want.frame_end, got.frame_end);
    endfunction
  endclass

endpackage

FILE: tb/sv/testbench.sv
// Top-level testbench for sobel_edge_threshold_top: stimulus, idling, checks.
// Depends on set_pkg and edge_scoreboard_pkg (the result predictor).
`timescale 1ns / 1ps

module testbench;
  import set_pkg::*;
  import edge_scoreboard_pkg::*;

  // Cycles with no transaction on any channel before the run is given up.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // Extra cycles after the last awaited result, covering the two-stage pipe.
  localparam int unsigned DRAIN_CYCLES   = 4;
  // Minimum random pixels per idling mode; three modes make up the random part.
  localparam int unsigned ITEMS_PER_MODE = 150;
  // Register index outside the map: the block must drop the write.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum int unsigned {
    TEX_NOISE,
    TEX_COL_STEP,
    TEX_COL_STEP_INV,
    TEX_ROW_STEP,
    TEX_SATURATED
  } texture_e;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  pixel_in_t             in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  result_t               out_data_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int unsigned    send_idle_pct = 0;
  int unsigned    recv_idle_pct = 0;
  int unsigned    quiet_cycles = 0;
  int unsigned    pixels_sent = 0;
  reg_write_t     pending_writes [$];
  edge_scoreboard edge_sb;

  always #2 clk_i = ~clk_i;

  sobel_edge_threshold_top #(
    .MAX_WIDTH  (LINE_DEPTH),
    .MAX_HEIGHT (FRAME_ROWS_MAX)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Receiver back-pressure: redraw the stall at every falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99, 0) < recv_idle_pct);
  end

  // Check every accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) edge_sb.check_result(out_data_o);
  end

  // Watchdog: count cycles in which no channel moves a transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offer one pixel, with random gaps before it; hold it until accepted.
  // Enter and leave at a falling edge.
  task automatic send_pixel(input pixel_in_t px);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    edge_sb.note_pixel(px);
    pixels_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every predicted result has come out, then let
  // the pipeline settle before any register write.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (edge_sb.awaited_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Settle, then issue the queued writes followed by the three size and
  // threshold writes, one transaction each.
  task automatic load_regs(input logic [CFG_DATA_W-1:0] w_data,
                           input logic [CFG_DATA_W-1:0] h_data,
                           input logic [CFG_DATA_W-1:0] t_data);
    reg_write_t wr;
    settle();
    pending_writes.push_back(reg_write_t'{CFG_IMAGE_WIDTH, w_data});
    pending_writes.push_back(reg_write_t'{CFG_IMAGE_HEIGHT, h_data});
    pending_writes.push_back(reg_write_t'{CFG_THRESHOLD, t_data});
    while (pending_writes.size() != 0) begin
      wr = pending_writes.pop_front();
      cfg_valid_i <= 1'b1;
      cfg_index_i <= wr.idx;
      cfg_data_i  <= wr.data;
      do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
      edge_sb.write_reg(wr.idx, wr.data);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [PIX_W-1:0] level(input logic lit);
    logic [PIX_W-1:0] jitter;
    jitter = PIX_W'($urandom_range(24, 0));
    return lit ? ~jitter : jitter;
  endfunction

  // Build a pixel of the chosen texture at raster position (c, r).
  function automatic pixel_in_t shaped_pixel(input texture_e tex, input int unsigned c,
                                             input int unsigned r, input int unsigned w);
    pixel_in_t px;
    logic      lit;
    case (tex)
      TEX_COL_STEP:     lit = (c >= w / 2);
      TEX_COL_STEP_INV: lit = (c < w / 2);
      TEX_ROW_STEP:     lit = (r % 3 == 2);
      default:          lit = 1'b0;
    endcase
    if (tex == TEX_NOISE) begin
      px = pixel_in_t'($urandom);
    end else if (tex == TEX_SATURATED) begin
      px.red   = $urandom_range(1, 0) ? 8'hFF : 8'h00;
      px.green = $urandom_range(1, 0) ? 8'hFF : 8'h00;
      px.blue  = $urandom_range(1, 0) ? 8'hFF : 8'h00;
    end else begin
      px.red   = level(lit);
      px.green = level(lit);
      px.blue  = level(lit);
    end
    return px;
  endfunction

  // Send one whole frame; call only at a frame boundary.
  task automatic send_frame(input texture_e tex);
    int unsigned w, h;
    w = edge_sb.row_len();
    h = edge_sb.frame_rows();
    for (int unsigned r = 0; r < h; r++) begin
      for (int unsigned c = 0; c < w; c++) send_pixel(shaped_pixel(tex, c, r, w));
    end
  endtask

  // Draw a random small setting, now and then with clamped or masked values.
  task automatic load_random_regs();
    logic [CFG_DATA_W-1:0] w_data, h_data, t_data;
    case ($urandom_range(9, 0))
      0:       w_data = CFG_DATA_W'($urandom_range(2, 0));
      1:       w_data = CFG_DATA_W'(13'h1000 | $urandom_range(12, 3));
      2:       w_data = CFG_DATA_W'($urandom_range(24, 17));
      default: w_data = CFG_DATA_W'($urandom_range(12, 3));
    endcase
    if ($urandom_range(9, 0) == 0) h_data = CFG_DATA_W'($urandom_range(2, 0));
    else h_data = CFG_DATA_W'($urandom_range(5, 3));
    case ($urandom_range(9, 0))
      0:       t_data = '0;
      1:       t_data = CFG_DATA_W'(1020);
      2:       t_data = CFG_DATA_W'($urandom_range(1023, 1021));
      3:       t_data = CFG_DATA_W'(13'h1C00 | $urandom_range(1023, 0));
      default: t_data = CFG_DATA_W'($urandom_range(500, 0));
    endcase
    if ($urandom_range(5, 0) == 0)
      pending_writes.push_back(reg_write_t'{CFG_UNUSED, CFG_DATA_W'($urandom)});
    load_regs(w_data, h_data, t_data);
  endtask

  initial begin
    // Directed frame: channel extremes, then a window with mixed gradients.
    pixel_in_t   corner_frame [9];
    int unsigned mode_start;
    corner_frame = '{
      pixel_in_t'{8'd0,   8'd0,   8'd0},   pixel_in_t'{8'd255, 8'd255, 8'd255},
      pixel_in_t'{8'd255, 8'd0,   8'd0},   pixel_in_t'{8'd0,   8'd255, 8'd0},
      pixel_in_t'{8'd0,   8'd0,   8'd255}, pixel_in_t'{8'd255, 8'd255, 8'd255},
      pixel_in_t'{8'd255, 8'd255, 8'd255}, pixel_in_t'{8'd255, 8'd255, 8'd255},
      pixel_in_t'{8'd0,   8'd0,   8'd0}
    };
    edge_sb     = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_IMAGE_WIDTH;
    cfg_data_i  = '0;
    // First idling mode: sender rarely idles, receiver mostly stalls.
    send_idle_pct = 6;
    recv_idle_pct = 69;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Smallest frame, sizes written below the floor so they clamp to 3,
    // threshold zero; an out-of-map index must change nothing.
    pending_writes.push_back(reg_write_t'{CFG_UNUSED, 13'h1FFF});
    load_regs(13'd0, 13'd2, 13'd0);
    foreach (corner_frame[k]) send_pixel(corner_frame[k]);

    // Dark left column, white right column: horizontal sum reaches 1020,
    // one above a threshold of 1019 (upper data bits are masked off).
    load_regs(13'h1003, 13'd3, 13'h1C00 | 13'd1019);
    for (int unsigned k = 0; k < 9; k++) begin
      send_pixel((k % 3 == 0) ? pixel_in_t'(0) :
                 (k % 3 == 2) ? pixel_in_t'({3{8'hFF}}) : pixel_in_t'($urandom));
    end

    // Largest sizes: width above the line store and height above the frame
    // limit both saturate; threshold out of reach of any gradient.
    load_regs(13'h0FFF, 13'h1FFF, 13'd1023);
    repeat (20) send_pixel(pixel_in_t'($urandom));
    // Exact maximum width, same effective size; hold the raster position.
    load_regs(13'h1800, 13'd4096, 13'd1020);
    repeat (20) send_pixel(pixel_in_t'($urandom));
    // Shrink the width under the column: the row wraps.
    load_regs(13'd6, 13'h1FFF, 13'd1021);
    repeat (27) send_pixel(pixel_in_t'($urandom));
    // Shrink the height under the row: the frame wraps; then close it.
    load_regs(13'd6, 13'd3, 13'd200);
    repeat (edge_sb.pixels_left_in_frame()) send_pixel(pixel_in_t'($urandom));

    // Random part: whole frames of random textures under random settings,
    // once per idling mode.
    for (int unsigned mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 6;
          recv_idle_pct = 69;
        end
        1: begin
          send_idle_pct = 69;
          recv_idle_pct = 6;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      mode_start = pixels_sent;
      while (pixels_sent - mode_start < ITEMS_PER_MODE) begin
        load_random_regs();
        repeat ($urandom_range(2, 1)) send_frame(texture_e'($urandom_range(4, 0)));
      end
    end

    // Drain every awaited result and let the pipe run empty.
    settle();
    $display("Run covered %0d pixels and %0d checked results over many frame settings",
             pixels_sent, edge_sb.results_checked);
    $display("Full windows %0d, edge marks inside windows %0d, frame ends %0d",
             edge_sb.windows_seen, edge_sb.edges_seen, edge_sb.frame_ends_seen);
    if (edge_sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
